// ===== hdl/wsm_pkg.sv =====
package wsm_pkg;

  localparam int PatternMax = 32;
  localparam int LenW       = $clog2(PatternMax + 1);
  localparam int IdxW       = $clog2(PatternMax);

  typedef logic [7:0] sym_t;

  localparam sym_t StarByte = 8'h2A;
  localparam sym_t NulByte  = 8'h00;

  typedef enum logic [1:0] {
    KindClear   = 2'd0,
    KindAppend  = 2'd1,
    KindSubject = 2'd2,
    KindEnd     = 2'd3
  } kind_e;

endpackage

// ===== hdl/wsm_advance.sv =====
// Next live-position vector for one subject byte.
// Star closure runs as a carry chain: a live star seeds a carry that ripples
// through the following run of stars.
module wsm_advance (
  input  logic [wsm_pkg::PatternMax:0]   live_i,
  input  logic [wsm_pkg::PatternMax-1:0] star_i,
  input  wsm_pkg::sym_t                  pattern_i [wsm_pkg::PatternMax],
  input  logic [wsm_pkg::LenW-1:0]       len_i,
  input  wsm_pkg::sym_t                  sym_i,
  output logic [wsm_pkg::PatternMax:0]   live_o
);
  import wsm_pkg::*;

  logic [PatternMax-1:0] in_len;
  logic [PatternMax-1:0] eq;
  logic [PatternMax-1:0] prop;
  logic [PatternMax:0]   seed;
  logic [PatternMax:0]   span;
  logic [PatternMax:0]   sum;
  logic [PatternMax:0]   carries;
  logic [PatternMax:0]   closed;

  always_comb begin
    for (int p = 0; p < PatternMax; p++) begin
      in_len[p] = (LenW'(p) < len_i);
      eq[p]     = (pattern_i[p] == sym_i);
    end
  end

  // a '*' subject byte takes a pattern star literally, no closure
  assign prop    = (sym_i != StarByte) ? (star_i & in_len) : '0;
  assign span    = {1'b0, prop};
  assign seed    = {1'b0, live_i[PatternMax-1:0] & prop};
  assign sum     = seed + span;
  assign carries = sum ^ seed ^ span;
  assign closed  = live_i | carries;

  always_comb begin
    live_o = '0;
    for (int p = 0; p < PatternMax; p++) begin
      if (closed[p] && in_len[p]) begin
        if (eq[p]) begin
          live_o[p+1] = 1'b1;
        end else if (star_i[p]) begin
          live_o[p] = 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/wildcard_star_matcher.sv =====
// Channel | Dir | Handshake                 | Fields                        | Transaction
// in      | in  | in_valid_i / in_ready_o   | kind_i, symbol_i              | pattern/subject item
// out     | out | out_valid_o / out_ready_i | matched_o, pattern_overflow_o | one per subject end
//
// Throughput: one input transaction per cycle for every kind, unless an end item waits behind a held result.
// Path: an end item loads the input register, then the result register, and the result
// is offered from there; the end item can wait in the input register while a result is held.
// Reset: asynchronous, active low; empty pattern, only position zero live.
// Stalls: out_ready_i low holds the result; the input stage keeps accepting
// until an end item has to wait behind the held result.
module wildcard_star_matcher (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    kind_i,
  input  logic [7:0]    symbol_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          matched_o,
  output logic          pattern_overflow_o
);
  import wsm_pkg::*;

  // input register
  logic  s1_valid_q;
  kind_e s1_kind_q;
  sym_t  s1_sym_q;

  // matcher state
  sym_t                  pattern_q [PatternMax];
  logic [PatternMax-1:0] star_q;
  logic [LenW-1:0]       len_q, len_d;
  logic [PatternMax:0]   live_q, live_d;
  logic                  ovf_q, ovf_d;

  // result register
  logic out_valid_q, out_valid_d;
  logic out_matched_q, out_ovf_q;

  logic                in_fire;
  logic                out_free;
  logic                s1_fire;
  logic                s1_is_end;
  logic                do_append;
  logic [LenW-1:0]     len_m1;
  logic                end_ok;
  logic [PatternMax:0] live_adv;

  assign out_free  = !out_valid_q || out_ready_i;
  assign s1_is_end = (s1_kind_q == KindEnd);
  // an end item waits only while the result slot is still occupied
  assign s1_fire   = s1_valid_q && (!s1_is_end || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= kind_e'(kind_i);
      s1_sym_q  <= symbol_i;
    end
  end

  wsm_advance u_advance (
    .live_i    (live_q),
    .star_i    (star_q),
    .pattern_i (pattern_q),
    .len_i     (len_q),
    .sym_i     (s1_sym_q),
    .live_o    (live_adv)
  );

  // trailing star at the end of the pattern may still absorb nothing
  assign len_m1 = len_q - 1'b1;
  assign end_ok = live_q[len_q] ||
                  ((len_q != '0) && live_q[len_m1] && star_q[len_m1[IdxW-1:0]]);

  assign do_append = s1_fire && (s1_kind_q == KindAppend) && (s1_sym_q != NulByte) &&
                     (len_q < LenW'(PatternMax));

  always_comb begin
    len_d       = len_q;
    live_d      = live_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (s1_fire) begin
      unique case (s1_kind_q)
        KindClear: begin
          len_d  = '0;
          ovf_d  = 1'b0;
          live_d = (PatternMax+1)'(1);
        end
        KindAppend: begin
          if (s1_sym_q != NulByte) begin
            if (len_q < LenW'(PatternMax)) begin
              len_d = len_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        KindSubject: begin
          if (s1_sym_q != NulByte) begin
            live_d = live_adv;
          end
        end
        KindEnd: begin
          live_d      = (PatternMax+1)'(1);
          out_valid_d = 1'b1;
        end
        default: begin
          live_d = live_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      live_q      <= (PatternMax+1)'(1);
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      live_q      <= live_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_append) begin
      pattern_q[len_q[IdxW-1:0]] <= s1_sym_q;
      star_q[len_q[IdxW-1:0]]    <= (s1_sym_q == StarByte);
    end
    if (s1_fire && s1_is_end) begin
      out_matched_q <= end_ok;
      out_ovf_q     <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = out_matched_q;
  assign pattern_overflow_o = out_ovf_q;

  // no live position ever lies past the stored pattern
  a_live_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((live_q >> len_q) >> 1) == '0)
    else $error("live position beyond pattern length");

  // overflow only happens with a full pattern
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (len_q == LenW'(PatternMax)))
    else $error("overflow flag set with room left");

  // end of subject restarts matching from position zero
  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_is_end) |=> (live_q == (PatternMax+1)'(1)))
    else $error("live positions not restarted after end of subject");

  // a result appears only behind an end item
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || out_ready_i) ##1 out_valid_q |-> $past(s1_fire && s1_is_end))
    else $error("result without end-of-subject item");

endmodule

// ===== test/wildcard_star_matcher_test.sv =====
module wildcard_star_matcher_test;
  import wsm_pkg::*;

  localparam int ItemTarget   = 700;
  localparam int QuietTail    = 100;     // last items run with no idling on either side
  localparam int DrainCycles  = 10;      // pad generously after the last result
  localparam int CycleLimit   = 200000;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  // Glob predictor: keeps its own pattern store and live-position vector and
  // queues one verdict per end-of-subject transaction.
  class glob_predictor;
    sym_t               pat[PatternMax];
    int                 len;
    logic [PatternMax:0] live;
    logic               ovf;
    verdict_t           verdicts_q[$];
    int                 mismatches;

    function new();
      foreach (pat[i]) pat[i] = NulByte;
      len        = 0;
      live       = (PatternMax+1)'(1);
      ovf        = 1'b0;
      mismatches = 0;
    endfunction

    // Step the live positions over one subject byte.
    function void step_subject(sym_t c);
      logic [PatternMax:0] closed;
      logic [PatternMax:0] nxt;
      closed = live;
      nxt    = '0;
      // Star closure, in order so runs of stars chain. A subject star skips it:
      // it must match a pattern star literally.
      if (c != StarByte) begin
        for (int p = 0; p < len; p++)
          if (closed[p] && pat[p] == StarByte) closed[p+1] = 1'b1;
      end
      for (int p = 0; p < len; p++) begin
        if (closed[p]) begin
          if (pat[p] == c) nxt[p+1] = 1'b1;
          else if (pat[p] == StarByte) nxt[p] = 1'b1;
        end
      end
      live = nxt;
    endfunction

    function void note_item(kind_e k, sym_t s);
      verdict_t v;
      case (k)
        KindClear: begin
          len  = 0;
          ovf  = 1'b0;
          live = (PatternMax+1)'(1);
        end
        KindAppend: begin
          if (s != NulByte) begin
            if (len < PatternMax) begin
              pat[len] = s;
              len++;
            end else begin
              ovf = 1'b1;
            end
          end
        end
        KindSubject: begin
          if (s != NulByte) step_subject(s);
        end
        default: begin
          // A trailing star may still be waiting at length-1; any earlier
          // star that was never closed over fails.
          v.matched = live[len];
          if (!v.matched && len > 0 && live[len-1] && pat[len-1] == StarByte)
            v.matched = 1'b1;
          v.overflow = ovf;
          verdicts_q.push_back(v);
          live = (PatternMax+1)'(1);
        end
      endcase
    endfunction

    function void check_result(logic m, logic o);
      verdict_t v;
      if (verdicts_q.size() == 0) begin
        $display("%0t: unexpected result matched=%0b overflow=%0b", $time, m, o);
        mismatches++;
        return;
      end
      v = verdicts_q.pop_front();
      if (m !== v.matched) begin
        $display("%0t: matched expected %0b actual %0b", $time, v.matched, m);
        mismatches++;
      end
      if (o !== v.overflow) begin
        $display("%0t: pattern_overflow expected %0b actual %0b", $time, v.overflow, o);
        mismatches++;
      end
    endfunction

    function int pending();
      return verdicts_q.size();
    endfunction
  endclass

  logic clk_i              = 1'b0;
  logic rst_ni             = 1'b0;
  logic in_valid_i         = 1'b0;
  logic in_ready_o;
  logic [1:0] kind_i       = 2'd0;
  logic [7:0] symbol_i     = 8'd0;
  logic out_valid_o;
  logic out_ready_i        = 1'b0;
  logic matched_o;
  logic pattern_overflow_o;

  glob_predictor predictor = new();
  int  items_sent  = 0;
  int  cycle_count = 0;
  bit  idle_on     = 1'b0;

  always #4 clk_i = ~clk_i;

  wildcard_star_matcher DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .symbol_i           (symbol_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .matched_o          (matched_o),
    .pattern_overflow_o (pattern_overflow_o)
  );

  // Hard stop in case a handshake never completes.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("wildcard_star_matcher_test: errors");
      $finish;
    end
  end

  // One input transaction. Inputs only move at rising edges, so the handshake
  // is sampled at the falling edge, where it is stable up to the next edge.
  task automatic send_item(kind_e k, sym_t s);
    bit took;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    symbol_i   <= s;
    forever begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
      if (took) break;
    end
    predictor.note_item(k, s);
    // NUL appends and subject bytes are dropped by the block; don't count them
    if (!((k == KindAppend || k == KindSubject) && s == NulByte)) items_sent++;
    if (items_sent > ItemTarget - QuietTail) idle_on = 1'b0;
  endtask

  task automatic send_text(kind_e k, string txt);
    for (int i = 0; i < txt.len(); i++) send_item(k, sym_t'(txt[i]));
  endtask

  // Mostly a small alphabet plus stars so matches are common; some full-range
  // bytes so every symbol bit toggles; the odd NUL.
  function automatic sym_t pick_sym();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return sym_t'("a" + $urandom_range(0, 2));
    if (r < 14) return StarByte;
    if (r < 19) return sym_t'($urandom_range(1, 255));
    return NulByte;
  endfunction

  // One well-formed stretch: optional clear, a pattern, then a few subjects,
  // many of them built from the pattern so they get deep into the positions; then maybe noise.
  task automatic run_sequence();
    sym_t pattern_q[$];
    sym_t subj_q[$];
    sym_t s;
    int   plen;
    if ($urandom_range(0, 9) != 0) send_item(KindClear, NulByte);
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
    for (int i = 0; i < plen; i++) begin
      s = pick_sym();
      pattern_q.push_back(s);
      send_item(KindAppend, s);
    end
    repeat ($urandom_range(1, 3)) begin
      subj_q.delete();
      if ($urandom_range(0, 1) == 0) begin
        foreach (pattern_q[i]) begin
          if (pattern_q[i] == StarByte && $urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(0, 3)) subj_q.push_back(pick_sym());
          end else begin
            subj_q.push_back(pattern_q[i]);
          end
        end
        // occasional single-byte corruption
        if (subj_q.size() > 0 && $urandom_range(0, 4) == 0)
          subj_q[$urandom_range(0, subj_q.size() - 1)] = pick_sym();
      end else begin
        repeat ($urandom_range(0, 8)) subj_q.push_back(pick_sym());
      end
      foreach (subj_q[i]) begin
        // pattern growth in the middle of a subject
        if ($urandom_range(0, 29) == 0) send_item(KindAppend, pick_sym());
        send_item(KindSubject, subj_q[i]);
      end
      send_item(KindEnd, NulByte);
    end
    // noise: any kind, any byte
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4))
        send_item(kind_e'($urandom_range(0, 3)), sym_t'($urandom_range(0, 255)));
    end
  endtask

  // Result side: random stall bursts on out_ready_i, check on each handshake.
  initial begin
    bit   fire;
    logic m;
    logic o;
    int   stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      fire = out_valid_o && out_ready_i;
      m    = matched_o;
      o    = pattern_overflow_o;
      @(posedge clk_i);
      if (fire) predictor.check_result(m, o);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pattern vs empty subject, ignored NULs, star in the
    // middle, subject star eating a pattern star, trailing star, non-final
    // star at end of subject, high byte, clear.
    send_item(KindEnd, NulByte);
    send_item(KindAppend, NulByte);
    send_item(KindSubject, NulByte);
    send_item(KindEnd, NulByte);
    send_text(KindAppend, "a*b");
    send_text(KindSubject, "axxb");
    send_item(KindEnd, NulByte);
    send_text(KindSubject, "a**b");
    send_item(KindEnd, NulByte);
    send_item(KindAppend, StarByte);
    send_text(KindSubject, "ab");
    send_item(KindSubject, 8'hFF);
    send_item(KindEnd, NulByte);
    send_item(KindClear, NulByte);
    send_text(KindAppend, "**");
    send_item(KindEnd, NulByte);
    send_item(KindClear, NulByte);
    send_item(KindAppend, 8'hFF);
    send_item(KindSubject, 8'hFF);
    send_item(KindEnd, NulByte);

    // Random phase; idling switches on and off between sequences.
    while (items_sent < ItemTarget) begin
      idle_on = (items_sent <= ItemTarget - QuietTail) && ($urandom_range(0, 3) != 0);
      run_sequence();
    end
    idle_on = 1'b0;
    in_valid_i <= 1'b0;

    while (predictor.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (predictor.mismatches == 0 && predictor.pending() == 0) begin
      $display("wildcard_star_matcher_test: clean");
    end else begin
      $display("wildcard_star_matcher_test: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/wsm_pkg.sv
hdl/wsm_advance.sv
hdl/wildcard_star_matcher.sv
test/wildcard_star_matcher_test.sv
